// ----- rtl/sha1sh_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types and constants for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    localparam int NUM_CHAIN  = 5;
    localparam int NUM_SCHED  = 16;
    localparam int NUM_ROUNDS = 80;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [6:0] LAST_ROUND    = 7'(NUM_ROUNDS - 1);

    localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/sha1sh_round.sv -----
// ----------------------------------------------------------------------------
// sha1sh_round
// One SHA-1 round: round function, constant select, the five-input add and
// the next message schedule word.
// ----------------------------------------------------------------------------
module sha1sh_round import sha1sh_pkg::*; (
    input  t_vars       i_vars,
    input  logic [6:0]  i_round,
    input  logic [31:0] i_w0,
    input  logic [31:0] i_w2,
    input  logic [31:0] i_w8,
    input  logic [31:0] i_w13,
    output t_vars       o_vars,
    output logic [31:0] o_w_new
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] x;
    logic [31:0] t;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_R0;
        end else if (i_round < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_R1;
        end else if (i_round < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_R2;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_R3;
        end
    end

    assign t = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + i_w0 + k;

    assign o_vars.a = t;
    assign o_vars.b = i_vars.a;
    assign o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
    assign o_vars.d = i_vars.c;
    assign o_vars.e = i_vars.d;

    // The schedule is a shift line, so slot zero always holds the word for
    // the current round and the new word enters at the far end.
    assign x       = i_w13 ^ i_w8 ^ i_w2 ^ i_w0;
    assign o_w_new = {x[30:0], x[31]};

endmodule

// ----- rtl/sha1_stream_hasher.sv -----
// Absorb word: taken while idle; the 64th byte of a block starts a compression
// (80 rounds on the shared round unit, then the chaining add).
// Finish word: one padding byte per cycle up to the end of the block, then one
// compression per block (one or two blocks), then five digest words.
// Input stalls while a block is compressed, so the round unit sets the sustained rate.
// Reset (synchronous) loads the initial chaining values and a zero bit count.
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream: byte absorb, padding, compression, digest output.
// ----------------------------------------------------------------------------
module sha1_stream_hasher import sha1sh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state, n_state;
    logic [31:0] r_chain [NUM_CHAIN];
    logic [31:0] n_chain [NUM_CHAIN];
    logic [31:0] r_sched [NUM_SCHED];
    logic [31:0] n_sched [NUM_SCHED];
    t_vars       r_vars, n_vars;
    logic [63:0] r_bit_count, n_bit_count;
    logic [5:0]  r_pos, n_pos;
    logic        r_fin, n_fin;
    logic        r_final, n_final;
    logic        r_first, n_first;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;

    logic        in_acc;
    logic        out_acc;
    logic        shift_en;
    logic        round_en;
    logic [7:0]  shift_byte;
    logic [7:0]  len_byte;
    logic [5:0]  len_shift;
    t_vars       rnd_vars;
    logic [31:0] w_new;

    sha1sh_round u_round (
        .i_vars  (r_vars),
        .i_round (r_round),
        .i_w0    (r_sched[0]),
        .i_w2    (r_sched[2]),
        .i_w8    (r_sched[8]),
        .i_w13   (r_sched[13]),
        .o_vars  (rnd_vars),
        .o_w_new (w_new)
    );

    assign in_acc  = i_valid && (r_state == ST_IDLE);
    assign out_acc = o_valid && !i_stall;

    // Length bytes go out most significant first at block positions 56..63.
    assign len_shift = {~r_pos[2:0], 3'b000};
    assign len_byte  = 8'(r_bit_count >> len_shift);

    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_vars      = r_vars;
        n_bit_count = r_bit_count;
        n_pos       = r_pos;
        n_fin       = r_fin;
        n_final     = r_final;
        n_first     = r_first;
        n_round     = r_round;
        n_idx       = r_idx;
        shift_en    = 1'b0;
        round_en    = 1'b0;
        shift_byte  = i_data_byte;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_ABSORB) begin
                        shift_en    = 1'b1;
                        n_bit_count = r_bit_count + 64'd8;
                        n_pos       = r_pos + 6'd1;
                    end else begin
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_final = (r_pos < LEN_FIELD_POS);
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                shift_en = 1'b1;
                if (r_first) begin
                    shift_byte = PAD_MARK;
                end else if (r_final && (r_pos >= LEN_FIELD_POS)) begin
                    shift_byte = len_byte;
                end else begin
                    shift_byte = 8'h00;
                end
                n_first = 1'b0;
                n_pos   = r_pos + 6'd1;
            end
            ST_ROUND: begin
                round_en = 1'b1;
                n_vars   = rnd_vars;
                n_round  = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_chain[0] = r_chain[0] + r_vars.a;
                n_chain[1] = r_chain[1] + r_vars.b;
                n_chain[2] = r_chain[2] + r_vars.c;
                n_chain[3] = r_chain[3] + r_vars.d;
                n_chain[4] = r_chain[4] + r_vars.e;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_final) begin
                    n_idx   = 3'd0;
                    n_state = ST_EMIT;
                end else begin
                    // Padding spilled past byte 55: one more block of zeros
                    // and the length follows.
                    n_final = 1'b1;
                    n_state = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (r_idx == LAST_WORD_IDX) begin
                        n_chain     = H_INIT;
                        n_bit_count = 64'd0;
                        n_pos       = 6'd0;
                        n_fin       = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // The byte that fills a block starts the compression.
        if (shift_en && (r_pos == LAST_BYTE_POS)) begin
            n_state = ST_ROUND;
            n_round = 7'd0;
            n_vars  = '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                        d: r_chain[3], e: r_chain[4]};
        end
    end

    always_comb begin
        n_sched = r_sched;
        if (shift_en) begin
            for (int i = 0; i < NUM_SCHED - 1; i++) begin
                n_sched[i] = {r_sched[i][23:0], r_sched[i + 1][31:24]};
            end
            n_sched[NUM_SCHED - 1] = {r_sched[NUM_SCHED - 1][23:0], shift_byte};
        end else if (round_en) begin
            for (int i = 0; i < NUM_SCHED - 1; i++) begin
                n_sched[i] = r_sched[i + 1];
            end
            n_sched[NUM_SCHED - 1] = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= H_INIT;
            r_bit_count <= 64'd0;
            r_pos       <= 6'd0;
            r_fin       <= 1'b0;
            r_final     <= 1'b0;
            r_first     <= 1'b0;
            r_round     <= 7'd0;
            r_idx       <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_bit_count <= n_bit_count;
            r_pos       <= n_pos;
            r_fin       <= n_fin;
            r_final     <= n_final;
            r_first     <= n_first;
            r_round     <= n_round;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sched <= n_sched;
        r_vars  <= n_vars;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_EMIT);
    assign o_digest_word = r_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == LAST_WORD_IDX);

endmodule

// ----- rtl/sha1sh_checker.sv -----
// ----------------------------------------------------------------------------
// sha1sh_checker
// Port-level checks for the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1sh_checker import sha1sh_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_opcode,
    input logic [7:0]  i_data_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // A stalled input word stays on offer unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_opcode) && $stable(i_data_byte))
        else $error("input word changed while stalled");

    // A stalled digest word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word)
            && $stable(o_word_index) && $stable(o_last_word))
        else $error("digest word changed while stalled");

    // The last mark sits on word four and only there.
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == LAST_WORD_IDX))
            && (o_word_index <= LAST_WORD_IDX))
        else $error("bad last mark or word index");

    // Digest words come out back to back in index order.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word |=>
            o_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words out of order");

    // No new word is taken in while the digest is being delivered.
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted during digest output");

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (.*);
